[sv/sha_pkg.sv]
// SHA-256 stream hasher package: payload structs, controller state enum,
// command/status structs, round constants and initial hash values.
// No dependencies.
package sha_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned BlockWords = 16;
    localparam int unsigned Rounds = 64;
    localparam int unsigned DigestWords = 8;
    localparam int unsigned CountW = 61;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenFillLimit = 6'd56;

    typedef enum logic [0:0] {
        KIND_DATA   = 1'b0,
        KIND_FINISH = 1'b1
    } kind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic put_data;
        logic put_pad;
        logic put_len;
        logic load;
        logic round;
        logic fold;
        logic emit;
        logic restart;
    } cmd_t;

    typedef struct packed {
        logic block_full;
        logic fill_high;
        logic last_round;
        logic last_emit;
    } status_t;

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [31:0] InitH [DigestWords] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[sv/sha_ctrl.sv]
// SHA-256 stream hasher controller state machine.
// Depends on sha_pkg.
module sha_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sha_pkg::in_item_t s_item,
    output logic             m_valid,
    input  logic             m_ready,
    input  sha_pkg::status_t status,
    output sha_pkg::cmd_t    cmd
);

    sha_pkg::state_t state_reg, state_next;
    logic            final_reg, final_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ST_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_item.kind == sha_pkg::KIND_FINISH) begin
                        state_next = sha_pkg::ST_PAD;
                    end else if (status.block_full) begin
                        state_next = sha_pkg::ST_LOAD;
                        final_next = 1'b0;
                    end
                end
            end
            sha_pkg::ST_PAD: begin
                state_next = sha_pkg::ST_LOAD;
                final_next = !status.fill_high;
            end
            sha_pkg::ST_LOAD: state_next = sha_pkg::ST_ROUND;
            sha_pkg::ST_ROUND: begin
                if (status.last_round) begin
                    state_next = sha_pkg::ST_FOLD;
                end
            end
            sha_pkg::ST_FOLD: begin
                if (final_reg) begin
                    state_next = sha_pkg::ST_EMIT;
                end else if (status.fill_high) begin
                    state_next = sha_pkg::ST_LOAD;
                    final_next = 1'b1;
                end else begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (m_ready && status.last_emit) begin
                    state_next = sha_pkg::ST_IDLE;
                    final_next = 1'b0;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // fill_high in FOLD means a pad block was just done and the length block follows.
    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                cmd.put_data = s_valid && (s_item.kind == sha_pkg::KIND_DATA);
            end
            sha_pkg::ST_PAD: begin
                cmd.put_pad = 1'b1;
                cmd.put_len = !status.fill_high;
            end
            sha_pkg::ST_LOAD: cmd.load = 1'b1;
            sha_pkg::ST_ROUND: cmd.round = 1'b1;
            sha_pkg::ST_FOLD: begin
                cmd.fold = 1'b1;
                cmd.put_len = !final_reg && status.fill_high;
            end
            sha_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                cmd.emit = m_ready;
                cmd.restart = m_ready && status.last_emit;
            end
            default: cmd = '0;
        endcase
    end

endmodule

[sv/sha_datapath.sv]
// SHA-256 stream hasher datapath: block buffer, schedule window, round unit,
// chaining words and digest output. Depends on sha_pkg.
module sha_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha_pkg::in_item_t  s_item,
    input  sha_pkg::cmd_t      cmd,
    output sha_pkg::status_t   status,
    output sha_pkg::out_item_t m_item
);

    logic [31:0] blk_reg [16];
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  fill_reg;
    logic [sha_pkg::CountW-1:0] count_reg;
    logic [5:0]  round_reg;
    logic [2:0]  emit_reg;
    logic        lenpend_reg;

    logic [7:0]  put_val;
    logic        put_en;
    logic [31:0] w_cur, w_new, sg0, sg1, s0, s1, ch, maj, t1, t2;
    logic [63:0] bits;

    assign put_en = cmd.put_data || cmd.put_pad;
    assign put_val = cmd.put_pad ? sha_pkg::PadByte : s_item.data_byte;
    assign bits = {count_reg, 3'b000};

    assign sg0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign sg1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
                 ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + sg0 + w_reg[9] + sg1;
    assign w_cur = w_reg[0];

    assign s1 = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
                ^ sha_pkg::rotr(v_reg[4], 25);
    assign ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1 = v_reg[7] + s1 + ch + sha_pkg::RoundK[round_reg] + w_cur;
    assign s0 = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
                ^ sha_pkg::rotr(v_reg[0], 22);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2 = s0 + maj;

    assign status.block_full = (fill_reg == 6'd63);
    assign status.fill_high = lenpend_reg || (fill_reg >= sha_pkg::LenFillLimit);
    assign status.last_round = (round_reg == 6'd63);
    assign status.last_emit = (emit_reg == 3'd7);

    assign m_item.digest_word = h_reg[emit_reg];
    assign m_item.word_index = emit_reg;
    assign m_item.last_word = (emit_reg == 3'd7);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::InitH[i];
            fill_reg <= '0;
            count_reg <= '0;
            round_reg <= '0;
            emit_reg <= '0;
            lenpend_reg <= 1'b0;
        end else begin
            if (put_en) begin
                blk_reg[fill_reg[5:2]] <= blk_reg[fill_reg[5:2]]
                    | ({24'd0, put_val} << (5'd24 - {fill_reg[1:0], 3'b000}));
                fill_reg <= fill_reg + 6'd1;
                if (cmd.put_data) begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (cmd.put_pad) begin
                lenpend_reg <= (fill_reg >= sha_pkg::LenFillLimit);
            end
            if (cmd.load) begin
                for (int i = 0; i < 16; i++) w_reg[i] <= blk_reg[i];
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                for (int i = 0; i < 16; i++) blk_reg[i] <= '0;
                round_reg <= '0;
            end
            if (cmd.put_len) begin
                blk_reg[14] <= bits[63:32];
                blk_reg[15] <= bits[31:0];
            end
            if (cmd.round) begin
                for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                w_reg[15] <= w_new;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.fold) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                round_reg <= '0;
                if (lenpend_reg && !cmd.put_len) begin
                    lenpend_reg <= lenpend_reg;
                end
                if (cmd.put_len) begin
                    lenpend_reg <= 1'b0;
                end
            end
            if (cmd.emit) begin
                emit_reg <= emit_reg + 3'd1;
            end
        end
    end

endmodule

[sv/sha256_stream_hasher_top.sv]
// Streaming SHA-256 hasher, top level: controller plus datapath.
// A data byte that completes a block is followed by load, 64 rounds and fold before input is ready again.
// A finish runs the pad block, and a separate length block when the pad leaves no room, then 8 digest transactions.
// One 64-round loop in the datapath sets the rate, one round per cycle.
// Synchronous active-low reset restores the initial hash values and clears the block.
// Depends on sha_pkg, sha_ctrl, sha_datapath.
module sha256_stream_hasher_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sha_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sha_pkg::out_item_t m_data
);

    sha_pkg::cmd_t    cmd;
    sha_pkg::status_t status;

    sha_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_item(s_data), .m_valid(m_valid), .m_ready(m_ready),
        .status(status), .cmd(cmd)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_data), .cmd(cmd),
        .status(status), .m_item(m_data)
    );

endmodule

[sv/sha_checker.sv]
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha_pkg and sha256_stream_hasher_top.
module sha_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input sha_pkg::out_item_t m_data
);

    a_no_input_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while digest is shown");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_word == (m_data.word_index == 3'd7)))
        else $error("last_word does not match word_index");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last_word) |=>
        (m_valid && m_data.word_index == $past(m_data.word_index) + 3'd1))
        else $error("digest words not consecutive");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher_top sha_checker u_sha_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

[dv/tb.sv]
// Self-checking testbench for sha256_stream_hasher_top: a byte-level SHA-256 predictor
// feeds a queue of expected digest words that the monitor checks in order.
// Depends on sha_pkg and the sha256_stream_hasher_top RTL.
`timescale 1ns / 1ps

module tb;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    sha_pkg::in_item_t  s_data;
    logic               m_valid;
    logic               m_ready;
    sha_pkg::out_item_t m_data;

    sha256_stream_hasher_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    sha_pkg::in_item_t  pending_items[$];
    sha_pkg::out_item_t expected_words[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_start = 0;
    bit          hold_off = 0;
    bit          send_pause = 0;

    logic [31:0] hash_state[8];
    logic [31:0] msg_block[16];
    logic [5:0]  fill_count;
    logic [60:0] byte_count;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] rr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic start_digest();
        for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::InitH[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        fill_count = '0;
        byte_count = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w[16];
        logic [31:0] v[8];
        logic [31:0] wt, t1, t2, a, b;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                a = w[(r - 15) & 15];
                b = w[(r - 2) & 15];
                wt = w[r & 15] + (rr(a, 7) ^ rr(a, 18) ^ (a >> 3)) + w[(r - 7) & 15]
                    + (rr(b, 17) ^ rr(b, 19) ^ (b >> 10));
                w[r & 15] = wt;
            end
            t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[r] + wt;
            t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
    endtask

    task automatic place_byte(input logic [5:0] pos, input logic [7:0] value);
        msg_block[pos[5:2]] |= {24'd0, value} << (24 - 8 * pos[1:0]);
    endtask

    task automatic predict_digest(input sha_pkg::in_item_t item);
        logic [63:0]        bit_len;
        sha_pkg::out_item_t word;
        if (item.kind == sha_pkg::KIND_DATA) begin
            place_byte(fill_count, item.data_byte);
            byte_count++;
            fill_count++;
            if (fill_count == 0) compress_block();
        end else begin
            bit_len = {byte_count, 3'b000};
            place_byte(fill_count, sha_pkg::PadByte);
            if (fill_count >= sha_pkg::LenFillLimit) compress_block();
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_state[i];
                word.word_index = i[2:0];
                word.last_word = (i == 7);
                expected_words.push_back(word);
            end
            start_digest();
        end
    endtask

    task automatic queue_message(input int length);
        sha_pkg::in_item_t item;
        for (int i = 0; i < length; i++) begin
            item.kind = sha_pkg::KIND_DATA;
            item.data_byte = 8'($urandom_range(0, 255));
            pending_items.push_back(item);
        end
        item.kind = sha_pkg::KIND_FINISH;
        item.data_byte = 8'($urandom_range(0, 255));
        pending_items.push_back(item);
    endtask

    task automatic queue_bytes(input logic [7:0] value, input int length);
        sha_pkg::in_item_t item;
        for (int i = 0; i < length; i++) begin
            item.kind = sha_pkg::KIND_DATA;
            item.data_byte = value;
            pending_items.push_back(item);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_digest(s_data);
            if (pending_items.size() > 0 && !send_pause
                && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_items.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    initial begin
        wait (hold_start);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (600) @(posedge aclk);
        hold_off <= 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected transaction %h", $time, m_data);
                    errors++;
                end else if (m_data !== expected_words[0]) begin
                    $display("%0t: mismatch expected %h actual %h", $time,
                        expected_words[0], m_data);
                    errors++;
                    void'(expected_words.pop_front());
                end else begin
                    void'(expected_words.pop_front());
                end
            end
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic random_phase(input int messages);
        for (int m = 0; m < messages; m++) begin
            case ($urandom_range(0, 7))
                0: queue_message(0);
                1: queue_message($urandom_range(52, 70));
                default: queue_message($urandom_range(1, 12));
            endcase
        end
    endtask

    initial begin
        aresetn = 0;
        start_digest();
        repeat (11) @(posedge aclk);
        aresetn <= 1;

        queue_message(0);
        queue_bytes(8'h00, 3);
        queue_bytes(8'hFF, 2);
        queue_message(0);
        queue_bytes(8'h61, 1);
        queue_bytes(8'h62, 1);
        queue_bytes(8'h63, 1);
        queue_message(0);
        queue_message(3);
        drain();
        queue_message(55);
        queue_message(56);
        queue_message(63);
        queue_message(64);
        drain();

        random_phase(2);
        drain();
        send_idle_pct = 80;
        random_phase(2);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 80;
        random_phase(2);
        drain();
        send_idle_pct = 10;
        recv_stall_pct = 10;
        hold_start = 1;
        random_phase(2);
        send_pause = 1;
        while (expected_words.size() > 0 || s_valid) @(posedge aclk);
        send_pause = 0;
        random_phase(1);
        drain();

        if (errors == 0) begin
            $display("[sha256_stream_hasher_top] OK");
        end else begin
            $display("[sha256_stream_hasher_top] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[sha256_stream_hasher_top] ERROR");
        $finish;
    end
endmodule

[sim.f]
sv/sha_pkg.sv
sv/sha_ctrl.sv
sv/sha_datapath.sv
sv/sha256_stream_hasher_top.sv
sv/sha_checker.sv
dv/tb.sv
